>>> rtl/core/apn_pkg.sv
package apn_pkg;

    // store size and derived widths
    localparam int MAX_PATH  = 256;
    localparam int ADDR_W    = $clog2(MAX_PATH);
    localparam int LEN_W     = $clog2(MAX_PATH + 1);
    localparam int OUT_LEN_W = 9;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_DOT   = 8'h2E;

    typedef enum logic [1:0]
    {
        FN_DIR  = 2'd0,
        FN_PATH = 2'd1,
        FN_READ = 2'd2,
        FN_NONE = 2'd3
    } func_t;

    typedef enum logic [1:0]
    {
        PUT_ITEM,
        PUT_SLASH,
        PUT_DOT
    } put_sel_t;

    typedef enum logic [1:0]
    {
        RD_INDEX,
        RD_POS,
        RD_LAST
    } rd_sel_t;

    typedef struct packed
    {
        logic     load_item;
        logic     clr_len;
        logic     put;
        put_sel_t put_sel;
        logic     pos_load;
        logic     pos_dec;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     len_from_pos;
        logic     strip;
        logic     slash_from_rd;
        logic     out_load;
        logic     done_flag;
    } dp_cmd_t;

    typedef struct packed
    {
        func_t func;
        logic  byte_nul;
        logic  byte_slash;
        logic  byte_dot;
        logic  len_nz;
        logic  len_gt1;
        logic  last_slash;
        logic  pos_nz;
        logic  pos_gt1;
        logic  rd_slash;
        logic  out_free;
    } dp_stat_t;

endpackage

>>> rtl/core/apn_datapath.sv
module apn_datapath
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  apn_pkg::func_t            in_func,
    input  logic [7:0]                in_byte,
    input  logic [7:0]                in_index,
    input  apn_pkg::dp_cmd_t          cmd,
    output apn_pkg::dp_stat_t         stat,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [7:0]                out_byte,
    output logic [apn_pkg::OUT_LEN_W-1:0] out_length,
    output logic                      out_done,
    output logic                      out_overflow
);
    import apn_pkg::*;

    localparam int CMP_W = LEN_W + 8;

    logic [7:0]       mem [MAX_PATH];

    func_t            func_reg;
    logic [7:0]       byte_reg;
    logic [7:0]       index_reg;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [LEN_W-1:0] pos_reg, pos_next;
    logic             last_slash_reg, last_slash_next;
    logic             ovf_reg, ovf_next;
    logic [7:0]       rd_data_reg;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [OUT_LEN_W-1:0] out_len_reg;
    logic             out_done_reg;
    logic             out_ovf_reg;

    logic [LEN_W-1:0]  base_len;
    logic [LEN_W-1:0]  index_ext;
    logic [7:0]        put_byte;
    logic              put_ok;
    logic [ADDR_W-1:0] rd_addr;
    logic              index_hit;

    assign base_len  = cmd.clr_len ? '0 : len_reg;
    assign put_ok    = cmd.put && (base_len < LEN_W'(MAX_PATH));
    assign index_ext = LEN_W'(index_reg);
    assign index_hit = CMP_W'(index_reg) < CMP_W'(len_reg);

    always_comb
    begin
        case (cmd.put_sel)
            PUT_ITEM:  put_byte = byte_reg;
            PUT_SLASH: put_byte = CH_SLASH;
            PUT_DOT:   put_byte = CH_DOT;
            default:   put_byte = byte_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.rd_sel)
            RD_INDEX: rd_addr = index_ext[ADDR_W-1:0];
            RD_POS:   rd_addr = ADDR_W'(pos_reg - LEN_W'(1));
            RD_LAST:  rd_addr = ADDR_W'(len_reg - LEN_W'(1));
            default:  rd_addr = index_ext[ADDR_W-1:0];
        endcase
    end

    // length, scan pointer and flags
    always_comb
    begin
        len_next        = len_reg;
        last_slash_next = last_slash_reg;
        ovf_next        = ovf_reg;
        pos_next        = pos_reg;
        if (cmd.put)
        begin
            if (put_ok)
            begin
                len_next        = base_len + LEN_W'(1);
                last_slash_next = (put_byte == CH_SLASH);
            end
            else
            begin
                len_next = base_len;
                ovf_next = 1'b1;
            end
        end
        else if (cmd.clr_len)
        begin
            len_next = '0;
        end
        else if (cmd.len_from_pos)
        begin
            len_next = (pos_reg > LEN_W'(1)) ? pos_reg - LEN_W'(1) : pos_reg;
        end
        else if (cmd.strip)
        begin
            len_next = len_reg - LEN_W'(1);
        end
        if (cmd.slash_from_rd)
        begin
            last_slash_next = (rd_data_reg == CH_SLASH);
        end
        if (cmd.pos_load)
        begin
            pos_next = len_reg;
        end
        else if (cmd.pos_dec)
        begin
            pos_next = pos_reg - LEN_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg        <= '0;
            last_slash_reg <= 1'b0;
            ovf_reg        <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            len_reg        <= len_next;
            last_slash_reg <= last_slash_next;
            ovf_reg        <= ovf_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        if (cmd.load_item)
        begin
            func_reg  <= in_func;
            byte_reg  <= in_byte;
            index_reg <= in_index;
        end
        if (cmd.out_load)
        begin
            out_byte_reg <= (func_reg == FN_READ && index_hit) ? rd_data_reg : 8'h00;
            out_len_reg  <= OUT_LEN_W'(len_reg);
            out_done_reg <= cmd.done_flag;
            out_ovf_reg  <= ovf_reg;
        end
    end

    // byte store, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (put_ok)
        begin
            mem[base_len[ADDR_W-1:0]] <= put_byte;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        stat.func       = func_reg;
        stat.byte_nul   = (byte_reg == CH_NUL);
        stat.byte_slash = (byte_reg == CH_SLASH);
        stat.byte_dot   = (byte_reg == CH_DOT);
        stat.len_nz     = (len_reg != '0);
        stat.len_gt1    = (len_reg > LEN_W'(1));
        stat.last_slash = last_slash_reg;
        stat.pos_nz     = (pos_reg != '0);
        stat.pos_gt1    = (pos_reg > LEN_W'(1));
        stat.rd_slash   = (rd_data_reg == CH_SLASH);
        stat.out_free   = !out_valid_reg || out_ready;
    end

    assign out_valid    = out_valid_reg;
    assign out_byte     = out_byte_reg;
    assign out_length   = out_len_reg;
    assign out_done     = out_done_reg;
    assign out_overflow = out_ovf_reg;

endmodule

>>> rtl/core/apn_ctrl.sv
module apn_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  apn_pkg::dp_stat_t stat,
    output apn_pkg::dp_cmd_t  cmd
);
    import apn_pkg::*;

    typedef enum logic [3:0]
    {
        S_IDLE,
        S_EXEC,
        S_SEP,
        S_DOTS,
        S_POP_INIT,
        S_SKIP_RD,
        S_SKIP_CHK,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_POP_SET,
        S_REF_RD,
        S_REF_CHK,
        S_END,
        S_FINISH
    } state_t;

    typedef enum logic [1:0]
    {
        PH_DIR,
        PH_FIRST,
        PH_PATH,
        PH_DONE
    } phase_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [1:0] dots_reg, dots_next;
    logic       open_reg, open_next;
    state_t     after_pop;

    // after a pop the terminating zero still needs its trailing slash strip
    assign after_pop = stat.byte_nul ? S_END : S_FINISH;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        dots_next  = dots_reg;
        open_next  = open_reg;
        cmd        = '0;
        cmd.done_flag = (phase_reg == PH_DONE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_FINISH;
                case (stat.func)
                    FN_DIR:
                    begin
                        if (phase_reg == PH_DONE || phase_reg == PH_DIR)
                        begin
                            // a finished job is dropped by the next directory beat
                            cmd.clr_len = (phase_reg == PH_DONE);
                            dots_next   = (phase_reg == PH_DONE) ? 2'd0 : dots_reg;
                            open_next   = (phase_reg == PH_DONE) ? 1'b0 : open_reg;
                            if (stat.byte_nul)
                            begin
                                phase_next = PH_FIRST;
                            end
                            else
                            begin
                                phase_next  = PH_DIR;
                                cmd.put     = 1'b1;
                                cmd.put_sel = PUT_ITEM;
                            end
                        end
                    end
                    FN_PATH:
                    begin
                        if (phase_reg == PH_FIRST)
                        begin
                            dots_next = 2'd0;
                            open_next = 1'b0;
                            if (stat.byte_nul)
                            begin
                                phase_next = PH_DONE;
                            end
                            else if (stat.byte_slash)
                            begin
                                cmd.clr_len = 1'b1;
                                cmd.put     = 1'b1;
                                cmd.put_sel = PUT_SLASH;
                                phase_next  = PH_PATH;
                            end
                            else
                            begin
                                phase_next = PH_PATH;
                                state_next = S_EXEC;
                            end
                        end
                        else if (phase_reg == PH_PATH)
                        begin
                            if (stat.byte_nul || stat.byte_slash)
                            begin
                                dots_next = 2'd0;
                                open_next = 1'b0;
                                if (!open_reg && dots_reg == 2'd2)
                                begin
                                    state_next = S_POP_INIT;
                                end
                                else if (stat.byte_nul)
                                begin
                                    state_next = S_END;
                                end
                            end
                            else if (stat.byte_dot && !open_reg && dots_reg != 2'd2)
                            begin
                                dots_next = dots_reg + 2'd1;
                            end
                            else if (open_reg)
                            begin
                                cmd.put     = 1'b1;
                                cmd.put_sel = PUT_ITEM;
                            end
                            else
                            begin
                                state_next = S_SEP;
                            end
                        end
                    end
                    FN_READ:
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_INDEX;
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_SEP:
            begin
                cmd.put     = stat.len_nz && !stat.last_slash;
                cmd.put_sel = PUT_SLASH;
                state_next  = S_DOTS;
            end
            S_DOTS:
            begin
                cmd.put = 1'b1;
                if (dots_reg != 2'd0)
                begin
                    cmd.put_sel = PUT_DOT;
                    dots_next   = dots_reg - 2'd1;
                end
                else
                begin
                    cmd.put_sel = PUT_ITEM;
                    open_next   = 1'b1;
                    state_next  = S_FINISH;
                end
            end
            S_POP_INIT:
            begin
                cmd.pos_load = 1'b1;
                state_next   = S_SKIP_RD;
            end
            S_SKIP_RD:
            begin
                if (stat.pos_gt1)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_POS;
                    state_next = S_SKIP_CHK;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SKIP_CHK:
            begin
                if (stat.rd_slash)
                begin
                    cmd.pos_dec = 1'b1;
                    state_next  = S_SKIP_RD;
                end
                else
                begin
                    // read data already holds the byte below pos
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_RD:
            begin
                if (stat.pos_nz)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_POS;
                    state_next = S_SCAN_CHK;
                end
                else
                begin
                    state_next = S_POP_SET;
                end
            end
            S_SCAN_CHK:
            begin
                if (!stat.rd_slash)
                begin
                    cmd.pos_dec = 1'b1;
                    state_next  = S_SCAN_RD;
                end
                else
                begin
                    state_next = S_POP_SET;
                end
            end
            S_POP_SET:
            begin
                cmd.len_from_pos = 1'b1;
                state_next       = S_REF_RD;
            end
            S_REF_RD:
            begin
                if (stat.len_nz)
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_LAST;
                    state_next = S_REF_CHK;
                end
                else
                begin
                    state_next = after_pop;
                end
            end
            S_REF_CHK:
            begin
                cmd.slash_from_rd = 1'b1;
                state_next        = after_pop;
            end
            S_END:
            begin
                cmd.strip  = stat.len_gt1 && stat.last_slash;
                phase_next = PH_DONE;
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_DIR;
            dots_reg  <= 2'd0;
            open_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            dots_reg  <= dots_next;
            open_reg  <= open_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

endmodule

>>> rtl/core/absolute_path_normalizer_unit.sv
// absolute path normaliser: stream a working directory (tuser 0) and then a path (tuser 1),
// one byte per beat, each ended by a zero byte; the canonical absolute path builds up in a
// 256-byte store and is read back a byte at a time with tuser 2 and an index. every input
// beat gives exactly one output beat carrying the read byte (zero unless a read hits below
// the current length), the current length, a path-done flag and a sticky overflow flag.
// one beat is in work at a time: a plain byte is accepted, executed and loaded into the output
// register, a byte that opens a component also passes a separator step and a dot step for the
// held-back dots, and a '..' pop walks back through the store over its single registered read
// port, one byte examined at a time, with set-up before and a length refresh after. the output
// register lets the next beat be taken while a result waits
module absolute_path_normalizer_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // byte_value [7:0], read_index [15:8]
    input  logic [1:0]  s_axis_tuser,   // func [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata    // out_byte [7:0], out_length [16:8], path_done [17],
                                        // overflow [18], zero [23:19]
);
    import apn_pkg::*;

    dp_cmd_t              cmd;
    dp_stat_t             stat;
    logic [7:0]           out_byte;
    logic [OUT_LEN_W-1:0] out_length;
    logic                 out_done;
    logic                 out_overflow;

    // sequencer: decodes each beat and steps the store through writes and pop scans
    apn_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // store, length, scan pointer and the output register
    apn_datapath u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_func      (func_t'(s_axis_tuser)),
        .in_byte      (s_axis_tdata[7:0]),
        .in_index     (s_axis_tdata[15:8]),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_byte     (out_byte),
        .out_length   (out_length),
        .out_done     (out_done),
        .out_overflow (out_overflow)
    );

    assign m_axis_tdata = {5'd0, out_overflow, out_done, out_length, out_byte};

endmodule

>>> rtl/core/apn_checker.sv
module apn_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    import apn_pkg::*;

    // a stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

    // only one beat in work: ready drops right after an accept
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second beat taken while one is in work");

    // length never exceeds the store
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[16:8] <= 9'(MAX_PATH))
    else $error("length beyond store size");

    // overflow flag is sticky across consecutive valid cycles
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && $past(m_axis_tvalid) && $past(m_axis_tdata[18]) |-> m_axis_tdata[18])
    else $error("overflow flag dropped");

endmodule

bind absolute_path_normalizer_unit apn_checker u_apn_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
